// ----- rtl/dqrs_pkg.sv -----
// ----------------------------------------------------------------------------
// dqrs_pkg
// Shared types, constants and helpers for the deque with running statistics.
// ----------------------------------------------------------------------------
package dqrs_pkg;

  // Ring buffer geometry.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of the transactions.
  localparam int OP_W        = 3;
  localparam int VAL_W       = 32;
  localparam int STAT_W      = 2;
  localparam int ECNT_W      = 5;
  localparam int SUM_W       = 36;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 112;

  localparam logic [IDX_W:0] DEPTH_X   = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_EXEC
  } eng_state_t;

  // One result; the first member lands in the highest bits when packed.
  typedef struct packed {
    logic [ECNT_W-1:0]       series;
    logic signed [SUM_W-1:0] checksum;
    logic signed [VAL_W-1:0] tail_value;
    logic signed [VAL_W-1:0] head_value;
    logic [ECNT_W-1:0]       entry_count;
    status_t                 status;
  } result_t;

  // Ring index plus an offset below DEPTH, wrapped once.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, idx} + {1'b0, off};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/dqrs_ram.sv -----
// ----------------------------------------------------------------------------
// dqrs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dqrs_ram #(
  parameter int  DEPTH_P = 16,
  parameter int  WIDTH_P = 32,
  localparam int ADDR_W  = $clog2(DEPTH_P)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [WIDTH_P-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [WIDTH_P-1:0] rd_data
);

  logic [WIDTH_P-1:0] mem_r [DEPTH_P];
  logic [WIDTH_P-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/dqrs_engine.sv -----
// ----------------------------------------------------------------------------
// dqrs_engine
// Operation sequencer: reads the neighbor entry, updates the ring pointers,
// cached head and tail, sum and series count, and writes pushed values.
// ----------------------------------------------------------------------------
module dqrs_engine
  import dqrs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Operation input
  input  logic                    op_valid,
  output logic                    op_ready,
  input  logic [OP_W-1:0]         op_code,
  input  logic signed [VAL_W-1:0] op_value,
  // Result output
  output logic                    res_valid,
  input  logic                    res_ready,
  output result_t                 res
);

  eng_state_t              state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        series_r, series_nxt;
  logic signed [VAL_W-1:0] head_r, head_nxt;
  logic signed [VAL_W-1:0] tail_r, tail_nxt;

  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [VAL_W-1:0]        rd_data;
  logic signed [VAL_W-1:0] nbr;
  op_t                     in_op;
  status_t                 status;

  assign nbr   = $signed(rd_data);
  assign in_op = op_t'(op_code);

  // Entry storage.
  dqrs_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (VAL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // State register and queue state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ENG_IDLE;
      front_r  <= '0;
      count_r  <= '0;
      sum_r    <= '0;
      series_r <= '0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      series_r <= series_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  // Next state, memory accesses and statistics update.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    series_nxt = series_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    op_ready   = 1'b0;
    res_valid  = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    status     = STAT_DONE;
    wr_addr    = ring_add(front_r, IDX_W'(count_r));
    // A back pop needs the entry before the tail, a front pop the one after the head.
    if (in_op == OP_POP_BACK) begin
      rd_addr = ring_add(front_r, IDX_W'(count_r - CNT_W'(2)));
    end else begin
      rd_addr = ring_add(front_r, IDX_W'(1));
    end

    unique case (state_r)
      ENG_IDLE: begin
        op_ready = 1'b1;
        if (op_valid) begin
          op_nxt    = in_op;
          val_nxt   = op_value;
          rd_en     = 1'b1;
          state_nxt = ENG_EXEC;
        end
      end
      ENG_EXEC: begin
        unique case (op_r) inside
          OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (count_r == DEPTH_C) begin
              status = STAT_FULL;
            end else begin
              wr_en     = res_ready;
              count_nxt = count_r + CNT_W'(1);
              sum_nxt   = sum_r + SUM_W'(val_r);
              if (op_r == OP_PUSH_FRONT) begin
                front_nxt = (front_r == '0) ? IDX_W'(DEPTH - 1)
                                            : front_r - IDX_W'(1);
                wr_addr   = front_nxt;
                head_nxt  = val_r;
                if (count_r == '0) begin
                  tail_nxt = val_r;
                end
              end else begin
                tail_nxt = val_r;
                if (count_r == '0) begin
                  head_nxt = val_r;
                end
              end
              if (count_r == '0) begin
                series_nxt = CNT_W'(1);
              end else if ((op_r == OP_PUSH_BACK && tail_r > val_r) ||
                           (op_r == OP_PUSH_FRONT && val_r > head_r)) begin
                series_nxt = series_r + CNT_W'(1);
              end
            end
          end
          OP_POP_BACK, OP_POP_FRONT: begin
            if (count_r == '0) begin
              status = STAT_EMPTY;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              if (op_r == OP_POP_BACK) begin
                sum_nxt  = sum_r - SUM_W'(tail_r);
                tail_nxt = nbr;
              end else begin
                sum_nxt   = sum_r - SUM_W'(head_r);
                head_nxt  = nbr;
                front_nxt = ring_add(front_r, IDX_W'(1));
              end
              if (count_r == CNT_W'(1)) begin
                series_nxt = '0;
              end else if ((op_r == OP_POP_BACK && nbr > tail_r) ||
                           (op_r == OP_POP_FRONT && head_r > nbr)) begin
                series_nxt = series_r - CNT_W'(1);
              end
            end
          end
          default: begin
            status = STAT_DONE;
          end
        endcase

        // Commit only when the result register can take the transaction.
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = ENG_IDLE;
        end else begin
          front_nxt  = front_r;
          count_nxt  = count_r;
          sum_nxt    = sum_r;
          series_nxt = series_r;
          head_nxt   = head_r;
          tail_nxt   = tail_r;
        end
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  // Result built from the state after the operation.
  always_comb begin
    res.status      = status;
    res.entry_count = ECNT_W'(count_nxt);
    res.series      = ECNT_W'(series_nxt);
    res.checksum    = sum_nxt;
    res.head_value  = (count_nxt == '0) ? '0 : head_nxt;
    res.tail_value  = (count_nxt == '0) ? '0 : tail_nxt;
  end

endmodule

// ----- rtl/deque_with_running_stats_core.sv -----
// ----------------------------------------------------------------------------
// deque_with_running_stats_core
// Double-ended queue of signed 32-bit values with running sum and series count.
// ----------------------------------------------------------------------------
// Each input transaction is one operation (push back, pop back, push front,
// pop front, query) and yields exactly one result transaction describing the
// queue afterwards. On acceptance in the idle state the entry next to the end
// being popped is read from the single-port-read entry RAM; the exec state
// then updates the pointers, sum and series count and writes a pushed value.
// One operation is in flight at a time, so no new transaction is accepted
// until the previous one has left the exec state; a result waiting in the
// output register does not hold off the next input, but the one after it
// waits until that result is taken. No clearing pass runs after reset.
module deque_with_running_stats_core
  import dqrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [2:0] opcode, [34:3] item_value, [39:35] zero
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [1:0] status, [6:2] entry_count, [38:7] head_value,
  // [70:39] tail_value, [106:71] checksum, [111:107] series
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    out_valid_r;
  result_t out_r;

  dqrs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (in_tvalid),
    .op_ready  (in_tready),
    .op_code   (in_tdata[OP_W-1:0]),
    .op_value  ($signed(in_tdata[OP_W+VAL_W-1:OP_W])),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

endmodule

// ----- rtl/dqrs_checker.sv -----
// ----------------------------------------------------------------------------
// dqrs_checker
// Port-level checks for the deque core, attached by bind.
// ----------------------------------------------------------------------------
module dqrs_checker
  import dqrs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [STAT_W-1:0] st;
  logic [ECNT_W-1:0] cnt;
  logic [ECNT_W-1:0] ser;

  assign st  = out_tdata[1:0];
  assign cnt = out_tdata[6:2];
  assign ser = out_tdata[111:107];

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One operation at a time: busy in the cycle after an accepted transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // Series count is zero exactly when the queue is empty, and never above the count.
  a_series_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((cnt == '0) == (ser == '0)) && (ser <= cnt))
    else $error("series count inconsistent with entry count");

  // A rejected push reports a full queue.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == STAT_FULL |-> cnt == ECNT_W'(DEPTH))
    else $error("push rejected while not full");

  // An ignored pop reports an empty queue with zero sum.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == STAT_EMPTY |-> cnt == '0 && out_tdata[106:71] == '0)
    else $error("pop ignored while not empty");

endmodule

bind deque_with_running_stats_core dqrs_checker u_dqrs_checker (.*);

// ----- verif/deque_with_running_stats_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_running_stats_core_tb
// Self-checking testbench for the deque with running sum and series count.
// ----------------------------------------------------------------------------
// A short table of directed operations covers the empty and full corners, the
// extreme values and the spare opcodes. Random operations follow, with a push
// bias that changes every few dozen transactions, so the queue swings between
// empty and full. A shadow copy of the deque predicts every result, and each
// result transaction is compared field by field with the oldest prediction.
// Both the sender and the receiver idle at random.
module deque_with_running_stats_core_tb;
  import dqrs_pkg::*;

  localparam int RANDOM_ITEMS   = 1800;
  localparam int MAX_GAP        = 17;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // Opcodes the block treats as a plain query.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h80000000;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    bit                      known;
    result_t                 res;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the deque.
  logic signed [VAL_W-1:0] shadow_store [DEPTH];
  int                      shadow_front;
  int                      shadow_count;
  logic signed [SUM_W-1:0] shadow_sum;
  int                      shadow_series;

  result_t  pending_results [$];
  dir_row_t dir_rows [$];
  int       error_count;
  int       idle_cycles;
  result_t  got_res;
  result_t  want_res;

  deque_with_running_stats_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Ring position of the entry pos places behind the front.
  function automatic int ring_slot(input int pos);
    return (shadow_front + pos) % DEPTH;
  endfunction

  // Applies one operation to the shadow deque and returns the result it yields.
  function automatic result_t apply_deque_op(input logic [OP_W-1:0] op,
                                             input logic signed [VAL_W-1:0] val);
    result_t                 r;
    logic signed [VAL_W-1:0] end_val;
    r = '0;
    r.status = STAT_DONE;
    if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
      if (shadow_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        // A new descending pair at either end opens a new series.
        if (shadow_count == 0) begin
          shadow_series = 1;
        end else if (op == OP_PUSH_BACK) begin
          if (shadow_store[ring_slot(shadow_count - 1)] > val) shadow_series++;
        end else if (val > shadow_store[ring_slot(0)]) begin
          shadow_series++;
        end
        if (op == OP_PUSH_BACK) begin
          shadow_store[ring_slot(shadow_count)] = val;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_store[shadow_front] = val;
        end
        shadow_count++;
        shadow_sum += val;
      end
    end else if (op == OP_POP_BACK || op == OP_POP_FRONT) begin
      if (shadow_count == 0) begin
        r.status = STAT_EMPTY;
      end else if (op == OP_POP_BACK) begin
        end_val = shadow_store[ring_slot(shadow_count - 1)];
        if (shadow_count == 1) begin
          shadow_series = 0;
        end else if (shadow_store[ring_slot(shadow_count - 2)] > end_val) begin
          shadow_series--;
        end
        shadow_sum -= end_val;
        shadow_count--;
      end else begin
        end_val = shadow_store[ring_slot(0)];
        if (shadow_count == 1) begin
          shadow_series = 0;
        end else if (end_val > shadow_store[ring_slot(1)]) begin
          shadow_series--;
        end
        shadow_sum -= end_val;
        shadow_front = (shadow_front + 1) % DEPTH;
        shadow_count--;
      end
    end
    r.entry_count = ECNT_W'(shadow_count);
    if (shadow_count > 0) begin
      r.head_value = shadow_store[ring_slot(0)];
      r.tail_value = shadow_store[ring_slot(shadow_count - 1)];
    end
    r.checksum = shadow_sum;
    r.series   = ECNT_W'(shadow_series);
    return r;
  endfunction

  // Often small values so that equal and descending neighbors are common.
  function automatic logic signed [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 9)) inside
      [0:3]: return $signed($urandom_range(0, 8)) - 32'sd4;
      4: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                         input bit known, input result_t res);
    dir_row_t row;
    row.op    = op;
    row.val   = val;
    row.known = known;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Offers one operation after the idle gap given by gap and records its prediction on
  // acceptance. A typed-in result replaces the prediction where one is given.
  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                         input int gap, input bit known, input result_t known_res);
    result_t predicted;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({val, op});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_deque_op(op, val);
    pending_results.insert(pending_results.size(), known ? known_res : predicted);
  endtask

  // Stops offering operations until every predicted result has come back.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Main stimulus: reset, directed table, random operations, final drain.
  initial begin : stimulus
    result_t                 empty_done;
    result_t                 empty_pop;
    result_t                 unused_res;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    int                      push_pct;
    int                      pick;
    int                      gap;
    bit                      sender_burst;

    error_count = 0;
    shadow_store = '{default: '0};
    shadow_front = 0;
    shadow_count = 0;
    shadow_sum = '0;
    shadow_series = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    empty_done = '0;
    empty_pop = '0;
    empty_pop.status = STAT_EMPTY;
    unused_res = '0;

    // Empty queue right after reset: query, both pops, a spare opcode.
    add_row(OP_QUERY,      '0,      1'b1, empty_done);
    add_row(OP_POP_BACK,   '0,      1'b1, empty_pop);
    add_row(OP_POP_FRONT,  VAL_MAX, 1'b1, empty_pop);
    add_row(OP_SPARE_C,    VAL_MIN, 1'b1, empty_done);
    // Fill to the brim from both ends with extremes and repeats.
    add_row(OP_PUSH_BACK,  VAL_MAX, 1'b0, unused_res);
    add_row(OP_PUSH_FRONT, VAL_MIN, 1'b0, unused_res);
    add_row(OP_PUSH_BACK,  '0,      1'b0, unused_res);
    add_row(OP_PUSH_FRONT, '1,      1'b0, unused_res);
    add_row(OP_PUSH_BACK,  32'sd1,  1'b0, unused_res);
    add_row(OP_PUSH_FRONT, -32'sd2, 1'b0, unused_res);
    add_row(OP_PUSH_BACK,  32'sd5,  1'b0, unused_res);
    add_row(OP_PUSH_BACK,  32'sd5,  1'b0, unused_res);
    add_row(OP_PUSH_FRONT, 32'sd100, 1'b0, unused_res);
    add_row(OP_PUSH_FRONT, -32'sd100, 1'b0, unused_res);
    add_row(OP_PUSH_BACK,  VAL_MIN, 1'b0, unused_res);
    add_row(OP_PUSH_FRONT, VAL_MAX, 1'b0, unused_res);
    add_row(OP_PUSH_BACK,  32'sd7,  1'b0, unused_res);
    add_row(OP_PUSH_FRONT, 32'sd3,  1'b0, unused_res);
    add_row(OP_PUSH_FRONT, 32'sd3,  1'b0, unused_res);
    add_row(OP_PUSH_BACK,  32'sd9,  1'b0, unused_res);
    // Full queue: both pushes are rejected, spare opcodes act as queries, then one pop from each end.
    add_row(OP_PUSH_BACK,  VAL_MIN, 1'b0, unused_res);
    add_row(OP_PUSH_FRONT, VAL_MAX, 1'b0, unused_res);
    add_row(OP_SPARE_A,    '1,      1'b0, unused_res);
    add_row(OP_SPARE_B,    '0,      1'b0, unused_res);
    add_row(OP_POP_BACK,   '0,      1'b0, unused_res);
    add_row(OP_POP_FRONT,  '0,      1'b0, unused_res);

    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].val, $urandom_range(0, MAX_GAP),
              dir_rows[i].known, dir_rows[i].res);
    end
    hold_until_drained();

    // Random operations with a push bias that shifts every 64 transactions.
    push_pct = 50;
    sender_burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 15;
          1:       push_pct = 35;
          2:       push_pct = 50;
          3:       push_pct = 65;
          default: push_pct = 85;
        endcase
        sender_burst = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) hold_until_drained();

      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      end else if (pick < 8) begin
        op = OP_QUERY;
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      val = draw_value();
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      send_op(op, val, gap, 1'b0, unused_res);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result receiver: random back-pressure with occasional stall-free stretches.
  initial begin : result_sink
    int stall;
    int taken;
    bit no_stall;
    out_tready <= 1'b0;
    taken = 0;
    no_stall = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 50 == 0) no_stall = ($urandom_range(0, 3) == 0);
      stall = no_stall ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      taken++;
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want_res = pending_results[0];
        pending_results.delete(0);
        if (got_res.status !== want_res.status)
          report_mismatch("status", longint'(got_res.status), longint'(want_res.status));
        if (got_res.entry_count !== want_res.entry_count)
          report_mismatch("entry_count", got_res.entry_count, want_res.entry_count);
        if (got_res.head_value !== want_res.head_value)
          report_mismatch("head_value", got_res.head_value, want_res.head_value);
        if (got_res.tail_value !== want_res.tail_value)
          report_mismatch("tail_value", got_res.tail_value, want_res.tail_value);
        if (got_res.checksum !== want_res.checksum)
          report_mismatch("checksum", got_res.checksum, want_res.checksum);
        if (got_res.series !== want_res.series)
          report_mismatch("series", got_res.series, want_res.series);
      end
    end
  end

  // Watchdog: too many cycles without any transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/dqrs_pkg.sv
rtl/dqrs_ram.sv
rtl/dqrs_engine.sv
rtl/deque_with_running_stats_core.sv
rtl/dqrs_checker.sv
verif/deque_with_running_stats_core_tb.sv
